// File: design/qet_pkg.sv
// ----------------------------------------------------------------------------
// qet_pkg: shared types and constants for the quoted escape tokenizer
// Input and result item structs, parse modes, result kinds, char codes.
// ----------------------------------------------------------------------------
`default_nettype none

package qet_pkg;

  localparam int QUEUE_DEPTH = 4;   // bundles between front and back
  localparam int MAX_RES     = 4;   // results one item can cause

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_end;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last;
  } out_t;

  typedef enum logic [2:0] {
    MODE_OUT    = 3'd0,
    MODE_QUOTED = 3'd1,
    MODE_ESC    = 3'd2,
    MODE_OCT    = 3'd3,
    MODE_HEX    = 3'd4,
    MODE_UNI    = 3'd5
  } mode_t;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_DROP = 2'd2;

  // all results of one item, in order
  typedef struct packed {
    logic [2:0]                cnt;
    logic [MAX_RES-1:0][1:0]   kind;
    logic [MAX_RES-1:0][7:0]   data;
  } bundle_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LU     = 8'h75;
  localparam logic [7:0] CH_LV     = 8'h76;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LA && c <= CH_LF) ||
           (c >= CH_UA && c <= CH_UF);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) t = c - CH_ZERO;
    else if (c >= CH_LA && c <= CH_LF) t = c - CH_LA + 8'd10;
    else if (c >= CH_UA && c <= CH_UF) t = c - CH_UA + 8'd10;
    return t[3:0];
  endfunction

endpackage

`default_nettype wire

// File: design/qet_front.sv
// ----------------------------------------------------------------------------
// qet_front: parser front end
// Holds the parse state, takes one item a cycle unless q_full and builds its result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module qet_front import qet_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire in_t     in_data,
  input  wire logic    q_full,
  output logic         q_push,
  output bundle_t      q_bundle
);

  mode_t       mode_r, mode_nxt;
  logic [15:0] ev_r, ev_nxt;
  logic [2:0]  dc_r, dc_nxt;
  logic        ne_r, ne_nxt;

  logic [7:0]  b;
  logic        fire;
  logic        consumed;
  logic        digit;
  logic [15:0] v;
  logic [15:0] ev_w;
  logic [2:0]  dc_w;
  logic [2:0]  lim;
  logic [2:0]  n;
  bundle_t     res;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign b        = in_data.char_byte;
  assign q_push   = fire && (res.cnt != 3'd0);
  assign q_bundle = res;

  always_comb begin
    mode_nxt = mode_r;
    ev_nxt   = ev_r;
    dc_nxt   = dc_r;
    ne_nxt   = ne_r;
    res      = '0;
    n        = 3'd0;
    consumed = 1'b0;
    digit    = 1'b0;
    v        = 16'd0;
    ev_w     = ev_r;
    dc_w     = dc_r;
    lim      = 3'd4;

    if (in_data.is_end) begin
      if (mode_r >= MODE_QUOTED && mode_r <= MODE_UNI) begin
        res.kind[n[1:0]] = KIND_DROP;
        n = n + 3'd1;
      end else if (ne_r) begin
        res.kind[n[1:0]] = KIND_END;
        n = n + 3'd1;
      end
      mode_nxt = MODE_OUT;
      ev_nxt   = 16'd0;
      dc_nxt   = 3'd0;
      ne_nxt   = 1'b0;
    end else begin
      unique case (mode_r)
        MODE_OCT, MODE_HEX, MODE_UNI: begin
          if (mode_r == MODE_OCT) begin
            digit = (b >= CH_ZERO) && (b <= CH_SEVEN);
            v     = {ev_r[12:0], 3'b000} + {13'd0, b[2:0]};
            lim   = 3'd3;
          end else begin
            digit = is_hex(b);
            v     = {ev_r[11:0], 4'b0000} + {12'd0, hex_val(b)};
            lim   = (mode_r == MODE_HEX) ? 3'd2 : 3'd4;
          end
          if (digit) begin
            ev_w = v;
            dc_w = dc_r + 3'd1;
          end
          if (digit && dc_w < lim) begin
            consumed = 1'b1;
            ev_nxt   = ev_w;
            dc_nxt   = dc_w;
          end else begin
            if (mode_r == MODE_OCT || (mode_r == MODE_HEX && dc_w != 3'd0)) begin
              res.data[n[1:0]] = ev_w[7:0];
              n = n + 3'd1;
            end else if (mode_r == MODE_UNI) begin
              if (ev_w <= 16'h007F) begin
                res.data[n[1:0]] = ev_w[7:0];
                n = n + 3'd1;
              end else if (ev_w <= 16'h07FF) begin
                res.data[n[1:0]] = 8'hC0 | {3'b000, ev_w[10:6]};
                n = n + 3'd1;
                res.data[n[1:0]] = 8'h80 | {2'b00, ev_w[5:0]};
                n = n + 3'd1;
              end else begin
                res.data[n[1:0]] = 8'hE0 | {4'b0000, ev_w[15:12]};
                n = n + 3'd1;
                res.data[n[1:0]] = 8'h80 | {2'b00, ev_w[11:6]};
                n = n + 3'd1;
                res.data[n[1:0]] = 8'h80 | {2'b00, ev_w[5:0]};
                n = n + 3'd1;
              end
            end
            if (n != 3'd0) ne_nxt = 1'b1;
            mode_nxt = MODE_QUOTED;
            ev_nxt   = 16'd0;
            dc_nxt   = 3'd0;
            consumed = digit;
          end
        end
        MODE_ESC: begin
          consumed = 1'b1;
          mode_nxt = MODE_QUOTED;
          ev_nxt   = 16'd0;
          dc_nxt   = 3'd0;
          unique case (b)
            CH_LA: begin res.data[0] = 8'd7;  n = 3'd1; end
            CH_LB: begin res.data[0] = 8'd8;  n = 3'd1; end
            CH_LF: begin res.data[0] = 8'd12; n = 3'd1; end
            CH_LN: begin res.data[0] = 8'd10; n = 3'd1; end
            CH_LR: begin res.data[0] = 8'd13; n = 3'd1; end
            CH_LT: begin res.data[0] = 8'd9;  n = 3'd1; end
            CH_LV: begin res.data[0] = 8'd11; n = 3'd1; end
            CH_BSLASH, CH_APOS, CH_QUOTE, CH_QMARK: begin
              res.data[0] = b;
              n = 3'd1;
            end
            CH_LX: mode_nxt = MODE_HEX;
            CH_LU: mode_nxt = MODE_UNI;
            default: begin
              if (b >= CH_ZERO && b <= CH_SEVEN) begin
                mode_nxt = MODE_OCT;
                ev_nxt   = {13'd0, b[2:0]};
                dc_nxt   = 3'd1;
              end
            end
          endcase
          if (n != 3'd0) ne_nxt = 1'b1;
        end
        default: ;
      endcase

      if (!consumed) begin
        if (mode_nxt == MODE_QUOTED) begin
          if (b == CH_QUOTE) begin
            res.kind[n[1:0]] = KIND_END;
            n = n + 3'd1;
            ne_nxt   = 1'b0;
            mode_nxt = MODE_OUT;
          end else if (b == CH_BSLASH) begin
            mode_nxt = MODE_ESC;
          end else begin
            res.data[n[1:0]] = b;
            n = n + 3'd1;
            ne_nxt = 1'b1;
          end
        end else begin
          // outside quotes (also the unused mode codes)
          if (b == CH_QUOTE) begin
            mode_nxt = MODE_QUOTED;
          end else if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
            if (ne_nxt) begin
              res.kind[n[1:0]] = KIND_END;
              n = n + 3'd1;
              ne_nxt = 1'b0;
            end
          end else begin
            res.data[n[1:0]] = b;
            n = n + 3'd1;
            ne_nxt = 1'b1;
          end
        end
      end
    end
    res.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_OUT;
      ev_r   <= 16'd0;
      dc_r   <= 3'd0;
      ne_r   <= 1'b0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      ev_r   <= ev_nxt;
      dc_r   <= dc_nxt;
      ne_r   <= ne_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/qet_fifo.sv
// ----------------------------------------------------------------------------
// qet_fifo: bundle queue
// Short queue of result bundles between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qet_fifo import qet_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire bundle_t wr_data,
  output logic         full,
  input  wire logic    pop,
  output logic         rd_valid,
  output bundle_t      rd_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push)
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

`default_nettype wire

// File: design/qet_back.sv
// ----------------------------------------------------------------------------
// qet_back: output stage
// Walks the head bundle one result a cycle, as out_ready allows, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qet_back import qet_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    q_valid,
  input  wire bundle_t q_bundle,
  output logic         q_pop,
  output logic         out_valid,
  input  wire logic    out_ready,
  output out_t         out_data
);

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  out_t       data_r, data_nxt;
  logic       load;
  logic       is_last;

  assign load      = q_valid && (!valid_r || out_ready);
  assign is_last   = ({1'b0, idx_r} == (q_bundle.cnt - 3'd1));
  assign q_pop     = load && is_last;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt          = 1'b1;
      data_nxt.kind      = q_bundle.kind[idx_r];
      data_nxt.data_byte = q_bundle.data[idx_r];
      data_nxt.last      = is_last;
      idx_nxt            = is_last ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

// File: design/quoted_escape_tokenizer.sv
// The first result of an item passes through the bundle queue and then the output register.
// Throughput: one input item per cycle while the queue is not full; results leave one
// per cycle while out_ready is high, and the bundle queue absorbs bursts.
// in_ready drops only when the bundle queue (QDEPTH bundles) is full.
// Reset: synchronous active-low rst_n; parser returns to outside quotes, queue
// and output register empty.
// ----------------------------------------------------------------------------
// quoted_escape_tokenizer: quoted argument tokenizer with C escapes
// Parser front end, bundle queue and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_escape_tokenizer import qet_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  logic    q_full, q_push, q_pop, q_valid;
  bundle_t wr_bundle, rd_bundle;

  qet_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_bundle (wr_bundle)
  );

  qet_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_data  (wr_bundle),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (rd_bundle)
  );

  qet_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_bundle  (rd_bundle),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
